@@ hw/rtl/fpr_pkg.sv @@
// shared types and constants for the programmable fsm reach/prune unit
// no dependencies; imported by fpr_ctrl, fpr_dp and the top level
`default_nettype none

package fpr_pkg;

    localparam int DEF_NUM_STATES = 8;
    localparam int RESET_STATE    = 7;

    // power-on transition table, repeats every eight states
    localparam int INIT_ZERO [8] = '{6, 2, 5, 1, 0, 3, 4, 6};
    localparam int INIT_ONE  [8] = '{1, 1, 7, 4, 3, 7, 5, 0};

    localparam int IN_WORD_W  = 8;
    localparam int OUT_WORD_W = 24;

    typedef enum logic [2:0] {
        OP_STEP   = 3'd0,
        OP_SET    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_PRUNE  = 3'd3,
        OP_DELETE = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_TARGET_DELETED = 2'd1;
    localparam logic [1:0] ST_REACHABLE      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic expand;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reach_op;
        logic stable;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpr_ctrl.sv @@
// sequencing controller: accept, closure rounds, result hand-off
// depends on fpr_pkg for the command and status structs
`default_nettype none

module fpr_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire fpr_pkg::dp_stat_t stat,
    output fpr_pkg::dp_cmd_t       cmd
);
    import fpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.reach_op ? S_CLOSE : S_FINISH;
                end
            end
            S_CLOSE:
            begin
                // one expansion round a cycle until nothing new is reached
                if (stat.stable)
                    state_next = S_FINISH;
                else
                    cmd.expand = 1'b1;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpr_dp.sv @@
// datapath: transition table cells, marks, reach vector and result register
// depends on fpr_pkg; driven by fpr_ctrl through dp_cmd_t
`default_nettype none

module fpr_dp #(
    parameter int NUM_STATES = fpr_pkg::DEF_NUM_STATES
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fpr_pkg::dp_cmd_t                    cmd,
    output fpr_pkg::dp_stat_t                        stat,
    input  wire logic [fpr_pkg::IN_WORD_W-1:0]       in_word,
    output logic      [fpr_pkg::OUT_WORD_W-1:0]      out_word
);
    import fpr_pkg::*;

    localparam int IW = $clog2(NUM_STATES);
    localparam logic [IW-1:0] CUR_RESET = IW'(RESET_STATE % NUM_STATES);

    // narrow 3-bit index folded into the state range
    function automatic logic [IW-1:0] wrap_idx(input logic [2:0] v);
        logic [2:0]    w;
        logic [IW+2:0] ext;
        w = v;
        for (int k = 0; k < 4; k++)
        begin
            if (int'(w) >= NUM_STATES)
                w = w - 3'(NUM_STATES);
        end
        ext = (IW+3)'(w);
        return ext[IW-1:0];
    endfunction

    function automatic logic [2:0] low3(input logic [IW-1:0] v);
        logic [IW+2:0] ext;
        ext = (IW+3)'(v);
        return ext[2:0];
    endfunction

    op_t                   in_op;
    op_t                   op_reg;
    logic                  sym_reg;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         cur_reg;
    logic [IW-1:0]         cur_next;
    logic [NUM_STATES-1:0] del_reg;
    logic [NUM_STATES-1:0] del_next;
    logic [NUM_STATES-1:0] rmark_reg;
    logic [NUM_STATES-1:0] rmark_next;
    logic [NUM_STATES-1:0] reach_reg;
    logic [NUM_STATES-1:0] grow;
    logic [NUM_STATES-1:0] wr0;
    logic [NUM_STATES-1:0] wr1;
    logic [IW-1:0]         n0 [NUM_STATES];
    logic [IW-1:0]         n1 [NUM_STATES];

    logic [1:0]            res_status;
    logic                  res_any;
    logic [NUM_STATES-1:0] res_mask;
    logic [NUM_STATES+7:0] mask_ext;
    logic [IW-1:0]         res_e0;
    logic [IW-1:0]         res_e1;
    logic                  res_ed;
    logic [OUT_WORD_W-1:0] out_reg;

    assign in_op         = op_t'(in_word[2:0]);
    assign stat.reach_op = (in_op == OP_QUERY) || (in_op == OP_PRUNE);
    assign stat.stable   = (grow == reach_reg);
    assign out_word      = out_reg;

    // command word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            sym_reg <= in_word[3];
            idx_reg <= wrap_idx(in_word[6:4]);
        end
    end

    // table cells, each with its own reset value
    for (genvar g = 0; g < NUM_STATES; g++)
    begin : g_cell
        localparam logic [IW-1:0] R0 = IW'(INIT_ZERO[g % 8] % NUM_STATES);
        localparam logic [IW-1:0] R1 = IW'(INIT_ONE[g % 8] % NUM_STATES);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                n0[g] <= R0;
                n1[g] <= R1;
            end
            else
            begin
                if (wr0[g])
                    n0[g] <= idx_reg;
                if (wr1[g])
                    n1[g] <= idx_reg;
            end
        end
    end

    // edge retarget enables, only the current state's row
    always_comb
    begin
        wr0 = '0;
        wr1 = '0;
        if (cmd.commit && op_reg == OP_SET && !del_reg[idx_reg])
        begin
            if (sym_reg)
                wr1[cur_reg] = 1'b1;
            else
                wr0[cur_reg] = 1'b1;
        end
    end

    // one expansion round of the closure
    always_comb
    begin
        grow = reach_reg;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            if (reach_reg[i])
                grow = grow | (NUM_STATES'(1) << n0[i]) | (NUM_STATES'(1) << n1[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            reach_reg <= NUM_STATES'(1) << cur_reg;
        else if (cmd.expand)
            reach_reg <= grow;
    end

    // result and state update of the held command
    always_comb
    begin
        cur_next   = cur_reg;
        del_next   = del_reg;
        rmark_next = rmark_reg;
        res_status = ST_OK;
        res_any    = 1'b0;
        res_mask   = '0;
        res_e0     = '0;
        res_e1     = '0;
        res_ed     = 1'b0;
        case (op_reg)
            OP_STEP:
            begin
                cur_next = sym_reg ? n1[cur_reg] : n0[cur_reg];
            end
            OP_SET:
            begin
                if (del_reg[idx_reg])
                    res_status = ST_TARGET_DELETED;
            end
            OP_QUERY:
            begin
                rmark_next = reach_reg;
                res_any    = |(~reach_reg);
                res_mask   = ~reach_reg & ~del_reg;
            end
            OP_PRUNE:
            begin
                rmark_next = reach_reg;
                res_any    = |(~reach_reg);
                res_mask   = ~reach_reg;
                del_next   = del_reg | ~reach_reg;
            end
            OP_DELETE:
            begin
                // uses the mark left by the last query or prune
                if (rmark_reg[idx_reg])
                    res_status = ST_REACHABLE;
                else
                begin
                    del_next[idx_reg] = 1'b1;
                    res_mask          = NUM_STATES'(1) << idx_reg;
                end
            end
            OP_READ:
            begin
                res_e0 = n0[idx_reg];
                res_e1 = n1[idx_reg];
                res_ed = del_reg[idx_reg];
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // only states 0..7 show in the mask
    assign mask_ext = (NUM_STATES+8)'(res_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= CUR_RESET;
            del_reg   <= '0;
            rmark_reg <= '0;
        end
        else if (cmd.commit)
        begin
            cur_reg   <= cur_next;
            del_reg   <= del_next;
            rmark_reg <= rmark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_reg <= {3'b000, res_ed, low3(res_e1), low3(res_e0), mask_ext[7:0],
                        res_any, low3(cur_next), res_status};
    end

endmodule

`default_nettype wire

@@ hw/rtl/programmable_fsm_reach_prune_unit.sv @@
// top level of the programmable fsm reach/prune unit
// depends on fpr_pkg, fpr_ctrl and fpr_dp
//
// usage
//   the slave channel takes one command word at a time; the master channel
//   returns exactly one result word for each command, in order.
//   s_tready is high only while the unit is idle; a command is taken when
//   s_tvalid and s_tready are both high.
//   step, set edge, delete named and read entry: once the command is taken,
//   the result is registered and m_tvalid raised as soon as the output
//   register is free; the next command can be taken after that.
//   garbage query and delete unreachable run the closure from the current
//   state, one expansion round a cycle until no new state appears, before
//   the result is registered in the same way.
//   the result sits in an output register; a new command is taken while it
//   waits, but if the receiver stalls the unit holds the next finished
//   result and stops taking commands until m_tready frees the register.
//   reset restores the power-on transition table, clears all deleted and
//   reachable marks, sets the current state to 7 (folded into the state
//   range) and drops any pending result word.
`default_nettype none

module programmable_fsm_reach_prune_unit #(
    parameter int NUM_STATES = fpr_pkg::DEF_NUM_STATES
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // opcode[2:0], symbol_bit[3], state_index[6:4], zero[7]
    input  wire logic [fpr_pkg::IN_WORD_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], current_state[4:2], any_unreachable[5], state_mask[13:6],
    // entry_on_zero[16:14], entry_on_one[19:17], entry_deleted[20], zero[23:21]
    output logic      [fpr_pkg::OUT_WORD_W-1:0] m_tdata
);
    import fpr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpr_dp #(
        .NUM_STATES (NUM_STATES)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_word  (s_tdata),
        .out_word (m_tdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/fpr_checker.sv @@
// port-level checks for the programmable fsm reach/prune unit
// depends on programmable_fsm_reach_prune_unit, attached by the bind below
`default_nettype none

module fpr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one command in flight at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    // an idle unit stays ready until a command word arrives
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> s_tready)
        else $error("ready dropped with no command taken");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[23:21] == 3'd0)
        else $error("bad status code or padding in result word");

endmodule

bind programmable_fsm_reach_prune_unit fpr_checker u_fpr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
